>>> rtl/local_relief_window_max_core_defines.svh
// Assertion macros used by the checker file of the local relief core.
`ifndef LOCAL_RELIEF_WINDOW_MAX_CORE_DEFINES_SVH
`define LOCAL_RELIEF_WINDOW_MAX_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LRWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another one on the following edge.
`define LRWM_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

>>> rtl/lrwm_pkg.sv
// Package of the local relief core: sizes, register codes, types.
package lrwm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 5;
    localparam int ELEV_BITS   = 24;
    localparam int LINES       = 2 * MAX_RADIUS;
    localparam int SIDE        = 2 * MAX_RADIUS + 1;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS   = $clog2(LINES);
    localparam int IDX_BITS    = $clog2(SIDE);
    localparam int OUT_BITS    = 24;
    localparam int ROW_BITS    = 16;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int RAD_BITS    = 3;
    localparam int ABS_BITS    = ELEV_BITS + 1;
    localparam int LINE_BITS   = LINES * ELEV_BITS;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef logic signed [ELEV_BITS-1:0] t_elev;
    typedef t_elev [SIDE-1:0]            t_column;
    typedef t_elev [LINES-1:0]           t_line_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_SCAN,
        S_EMIT
    } t_state;

    // Window control from the sequencer
    typedef struct packed {
        logic                shift;
        logic                start;
        logic                scan;
        logic [IDX_BITS-1:0] idx;
    } t_win_ctrl;

endpackage

>>> rtl/local_relief_window_max_core.sv
// Top level of the local relief core: line store, sequencer, statistics, ports.
// Each elevation sample passes through the sequencer states in order: IDLE accepts
// it and reads its column word from the line store, LOAD loads the new window column
// and writes the word back, START latches the centre, SCAN walks the window columns
// through the compare tree, and EMIT hands the result to the output register, for an
// interior cell waiting while that register is held full. The line store is one memory of MAX_WIDTH words,
// each holding all 2*MAX_RADIUS buffered rows of one column, so a sample costs
// one read and one write. The store needs no clearing pass after reset. A
// finished result waits in the output register while the next sample is taken.
module local_relief_window_max_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // [23:0] elevation
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] cell_row, [25:16] cell_col, [49:26] relief,
    // [73:50] min_relief, [97:74] max_relief, [103:98] zero
    output logic [103:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast,   // frame_last
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    lrwm_pkg::t_state r_state, n_state;

    logic [lrwm_pkg::WIDTH_BITS-1:0]  r_width;
    logic [lrwm_pkg::HEIGHT_BITS-1:0] r_height;
    logic [lrwm_pkg::RAD_BITS-1:0]    r_radius;

    logic [lrwm_pkg::COL_BITS-1:0]  r_col;
    logic [lrwm_pkg::ROW_BITS-1:0]  r_row;
    logic [lrwm_pkg::SLOT_BITS-1:0] r_slot;
    logic [lrwm_pkg::OUT_BITS-1:0]  r_min, r_max;
    logic                           r_have;
    logic [lrwm_pkg::IDX_BITS-1:0]  r_idx;

    lrwm_pkg::t_elev      r_sample;
    lrwm_pkg::t_line_word r_rd_word;
    logic [lrwm_pkg::LINE_BITS-1:0] mem [lrwm_pkg::MAX_WIDTH];

    logic                                r_out_valid;
    logic                                r_out_last;
    logic [lrwm_pkg::ROW_BITS-1:0]       r_out_row;
    logic [lrwm_pkg::COL_BITS-1:0]       r_out_col;
    logic [lrwm_pkg::OUT_BITS-1:0]       r_out_rel, r_out_min, r_out_max;

    logic                               in_beat, cfg_wr, cfg_hit;
    logic [1:0]                         cfg_idx;
    logic [lrwm_pkg::WIDTH_BITS-1:0]    eff_w;
    logic [lrwm_pkg::HEIGHT_BITS-1:0]   eff_h;
    logic [lrwm_pkg::RAD_BITS-1:0]      eff_r;
    logic [lrwm_pkg::ROW_BITS:0]        row_next;
    logic [lrwm_pkg::WIDTH_BITS-1:0]    col_next;
    logic                               row_end, last, interior, out_free;
    logic                               finish, load_out;
    lrwm_pkg::t_win_ctrl                ctrl;
    lrwm_pkg::t_column                  new_col;
    lrwm_pkg::t_line_word               wr_word;
    logic [lrwm_pkg::OUT_BITS-1:0]      relief, n_min, n_max;

    // Configuration port
    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[3:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_hit  = cfg_wr && (cfg_idx == lrwm_pkg::CFG_WIDTH
                              || cfg_idx == lrwm_pkg::CFG_HEIGHT
                              || cfg_idx == lrwm_pkg::CFG_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lrwm_pkg::WIDTH_BITS'(1024);
            r_height <= lrwm_pkg::HEIGHT_BITS'(1024);
            r_radius <= lrwm_pkg::RAD_BITS'(5);
        end else if (cfg_wr) begin
            case (cfg_idx)
                lrwm_pkg::CFG_WIDTH:  r_width  <= i_pwdata[lrwm_pkg::WIDTH_BITS-1:0];
                lrwm_pkg::CFG_HEIGHT: r_height <= i_pwdata[lrwm_pkg::HEIGHT_BITS-1:0];
                lrwm_pkg::CFG_RADIUS: r_radius <= i_pwdata[lrwm_pkg::RAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lrwm_pkg::CFG_WIDTH:  o_prdata = 32'(r_width);
            lrwm_pkg::CFG_HEIGHT: o_prdata = 32'(r_height);
            lrwm_pkg::CFG_RADIUS: o_prdata = 32'(r_radius);
            default:              o_prdata = '0;
        endcase
    end

    // Effective grid size and radius
    always_comb begin
        if (r_width == '0) begin
            eff_w = lrwm_pkg::WIDTH_BITS'(1);
        end else if (r_width > lrwm_pkg::WIDTH_BITS'(lrwm_pkg::MAX_WIDTH)) begin
            eff_w = lrwm_pkg::WIDTH_BITS'(lrwm_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        eff_h = (r_height == '0) ? lrwm_pkg::HEIGHT_BITS'(1) : r_height;
        if (r_radius == '0 || r_radius > lrwm_pkg::RAD_BITS'(lrwm_pkg::MAX_RADIUS)) begin
            eff_r = lrwm_pkg::RAD_BITS'(lrwm_pkg::MAX_RADIUS);
        end else begin
            eff_r = r_radius;
        end
    end

    assign col_next = lrwm_pkg::WIDTH_BITS'(r_col) + 1'b1;
    assign row_next = (lrwm_pkg::ROW_BITS + 1)'(r_row) + 1'b1;
    assign row_end  = col_next >= eff_w;
    assign last     = row_end && (row_next >= (lrwm_pkg::ROW_BITS + 1)'(eff_h));
    assign interior = (r_row >= lrwm_pkg::ROW_BITS'({eff_r, 1'b0}))
                   && (r_col >= lrwm_pkg::COL_BITS'({eff_r, 1'b0}));
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrwm_pkg::S_IDLE:  if (i_s_axis_tvalid) n_state = lrwm_pkg::S_LOAD;
            lrwm_pkg::S_LOAD:  n_state = lrwm_pkg::S_START;
            lrwm_pkg::S_START: n_state = lrwm_pkg::S_SCAN;
            lrwm_pkg::S_SCAN: begin
                if (r_idx == lrwm_pkg::IDX_BITS'(lrwm_pkg::SIDE - 1)) begin
                    n_state = lrwm_pkg::S_EMIT;
                end
            end
            lrwm_pkg::S_EMIT:  if (!interior || out_free) n_state = lrwm_pkg::S_IDLE;
            default:           n_state = lrwm_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        ctrl            = '0;
        finish          = 1'b0;
        load_out        = 1'b0;
        ctrl.idx        = r_idx;
        case (r_state)
            lrwm_pkg::S_IDLE:  o_s_axis_tready = 1'b1;
            lrwm_pkg::S_LOAD:  ctrl.shift = 1'b1;
            lrwm_pkg::S_START: ctrl.start = 1'b1;
            lrwm_pkg::S_SCAN:  ctrl.scan  = 1'b1;
            lrwm_pkg::S_EMIT: begin
                finish   = !interior || out_free;
                load_out = interior && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Column step counter for the window walk
    always_ff @(posedge i_clk) begin
        if (r_state == lrwm_pkg::S_START) begin
            r_idx <= '0;
        end else if (r_state == lrwm_pkg::S_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Line store: read the column word on accept, write it back on load
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_rd_word <= mem[r_col];
            r_sample  <= i_s_axis_tdata;
        end
        if (ctrl.shift) begin
            mem[r_col] <= wr_word;
        end
    end

    // Build the new window column and the word to write back
    always_comb begin
        logic [lrwm_pkg::SLOT_BITS-1:0] lane;
        new_col[0] = r_sample;
        for (int dr = 1; dr < lrwm_pkg::SIDE; dr++) begin
            if (r_slot >= lrwm_pkg::SLOT_BITS'(dr)) begin
                lane = r_slot - lrwm_pkg::SLOT_BITS'(dr);
            end else begin
                lane = r_slot + lrwm_pkg::SLOT_BITS'(lrwm_pkg::LINES - dr);
            end
            new_col[dr] = r_rd_word[lane];
        end
        wr_word         = r_rd_word;
        wr_word[r_slot] = r_sample;
    end

    lrwm_window u_window (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_col    (new_col),
        .i_radius (eff_r),
        .o_relief (relief)
    );

    // Running statistics with the first relief seeding both
    always_comb begin
        if (!r_have) begin
            n_min = relief;
            n_max = relief;
        end else begin
            n_min = (relief < r_min) ? relief : r_min;
            n_max = (relief > r_max) ? relief : r_max;
        end
    end

    // Frame counters and statistics; a register write starts a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit || (finish && last)) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_have <= 1'b0;
        end else if (finish) begin
            if (load_out) begin
                r_min  <= n_min;
                r_max  <= n_max;
                r_have <= 1'b1;
            end
            if (row_end) begin
                r_col  <= '0;
                r_row  <= row_next[lrwm_pkg::ROW_BITS-1:0];
                r_slot <= (r_slot == lrwm_pkg::SLOT_BITS'(lrwm_pkg::LINES - 1))
                        ? '0 : r_slot + 1'b1;
            end else begin
                r_col  <= col_next[lrwm_pkg::COL_BITS-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row  <= r_row - lrwm_pkg::ROW_BITS'(eff_r);
            r_out_col  <= r_col - lrwm_pkg::COL_BITS'(eff_r);
            r_out_rel  <= relief;
            r_out_min  <= n_min;
            r_out_max  <= n_max;
            r_out_last <= last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {6'b0, r_out_max, r_out_min, r_out_rel, r_out_col, r_out_row};

endmodule

>>> rtl/lrwm_window.sv
// Square sample window with column-serial relief search.
module lrwm_window (
    input  logic                          i_clk,
    input  lrwm_pkg::t_win_ctrl           i_ctrl,
    input  lrwm_pkg::t_column             i_col,
    input  logic [lrwm_pkg::RAD_BITS-1:0] i_radius,
    output logic [lrwm_pkg::OUT_BITS-1:0] o_relief
);

    lrwm_pkg::t_column            r_win [lrwm_pkg::SIDE];
    lrwm_pkg::t_elev              r_centre;
    logic [lrwm_pkg::OUT_BITS-1:0] r_relief;

    lrwm_pkg::t_elev               centre;
    logic [lrwm_pkg::IDX_BITS:0]   span;
    logic [lrwm_pkg::OUT_BITS-1:0] a   [12];
    logic [lrwm_pkg::OUT_BITS-1:0] l1  [6];
    logic [lrwm_pkg::OUT_BITS-1:0] l2  [3];
    logic [lrwm_pkg::OUT_BITS-1:0] l3  [2];
    logic [lrwm_pkg::OUT_BITS-1:0] col_max;

    assign span = {{(lrwm_pkg::IDX_BITS - lrwm_pkg::RAD_BITS){1'b0}}, i_radius, 1'b0};

    // Select the centre sample on the diagonal
    always_comb begin
        centre = r_win[0][0];
        for (int k = 0; k < lrwm_pkg::SIDE; k++) begin
            if (k == int'(i_radius)) begin
                centre = r_win[k][k];
            end
        end
    end

    // Absolute differences of the column at the front, rows beyond the window dropped
    always_comb begin
        logic signed [lrwm_pkg::ABS_BITS-1:0] diff;
        logic        [lrwm_pkg::ABS_BITS-1:0] mag;
        for (int dr = 0; dr < 12; dr++) begin
            a[dr] = '0;
        end
        for (int dr = 0; dr < lrwm_pkg::SIDE; dr++) begin
            diff = {r_win[0][dr][lrwm_pkg::ELEV_BITS-1], r_win[0][dr]}
                 - {r_centre[lrwm_pkg::ELEV_BITS-1], r_centre};
            mag  = diff[lrwm_pkg::ABS_BITS-1] ? lrwm_pkg::ABS_BITS'(-diff)
                                               : lrwm_pkg::ABS_BITS'(diff);
            if ((lrwm_pkg::IDX_BITS + 1)'(dr) > span) begin
                a[dr] = '0;
            end else if (mag > lrwm_pkg::ABS_BITS'(2 ** lrwm_pkg::OUT_BITS - 1)) begin
                a[dr] = '1;
            end else begin
                a[dr] = lrwm_pkg::OUT_BITS'(mag);
            end
        end
    end

    // Reduce the column with a compare tree
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            l1[i] = (a[2*i] > a[2*i+1]) ? a[2*i] : a[2*i+1];
        end
        for (int i = 0; i < 3; i++) begin
            l2[i] = (l1[2*i] > l1[2*i+1]) ? l1[2*i] : l1[2*i+1];
        end
        l3[0]   = (l2[0] > l2[1]) ? l2[0] : l2[1];
        l3[1]   = l2[2];
        col_max = (l3[0] > l3[1]) ? l3[0] : l3[1];
    end

    // Shift in a new column, or rotate the window one column per scan step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win[0] <= i_col;
            for (int dc = 1; dc < lrwm_pkg::SIDE; dc++) begin
                r_win[dc] <= r_win[dc-1];
            end
        end else if (i_ctrl.scan) begin
            r_win[lrwm_pkg::SIDE-1] <= r_win[0];
            for (int dc = 0; dc < lrwm_pkg::SIDE - 1; dc++) begin
                r_win[dc] <= r_win[dc+1];
            end
        end
    end

    // Latch the centre, then accumulate the largest difference
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_centre <= centre;
            r_relief <= '0;
        end else if (i_ctrl.scan && ({1'b0, i_ctrl.idx} <= span)
                     && (col_max > r_relief)) begin
            r_relief <= col_max;
        end
    end

    assign o_relief = r_relief;

endmodule

>>> rtl/lrwm_checker.sv
// Port-level checks of the local relief core and their binding.
`include "local_relief_window_max_core_defines.svh"

module lrwm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] o_m_axis_tdata
);

    // Hold a stalled result beat
    `LRWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid,
        "result beat dropped while stalled")

    // Relief lies between the running extremes
    `LRWM_ASSERT(a_stats_order, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tdata[73:50] <= o_m_axis_tdata[49:26]
                             && o_m_axis_tdata[49:26] <= o_m_axis_tdata[97:74]),
        "relief outside running min and max")

    // A sample beat occupies the core for the following cycle
    `LRWM_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
        "sample accepted while busy")

endmodule

bind local_relief_window_max_core lrwm_checker u_lrwm_checker (.*);

>>> bench/local_relief_window_max_core_tb.sv
// Self-checking stream testbench of the local relief window core.
module local_relief_window_max_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  col;
        logic [23:0] rel;
        logic [23:0] rmin;
        logic [23:0] rmax;
        logic        last;
    } t_relief;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic         s_ready;
    logic [23:0]  s_data = 0;
    logic         m_valid;
    logic         m_ready = 0;
    logic [103:0] m_data;
    logic         m_last;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;

    local_relief_window_max_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .o_m_axis_tlast(m_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    initial forever #10 i_clk = ~i_clk;

    // Predictor state
    logic [10:0] cfg_w = 1024;
    logic [15:0] cfg_h = 1024;
    logic [2:0]  cfg_r = 5;
    logic signed [23:0] lines_q [lrwm_pkg::LINES][lrwm_pkg::MAX_WIDTH];
    logic signed [23:0] win_q [lrwm_pkg::SIDE][lrwm_pkg::SIDE];
    int unsigned col_cnt, row_cnt;
    logic [23:0] run_min, run_max;
    bit          seen_valid;

    t_relief     expected_q[$];
    int          errors = 0;
    bit          idle_on = 1;
    int          hold_off = 0;

    task automatic restart_frame();
        col_cnt = 0; row_cnt = 0; run_min = 0; run_max = 0; seen_valid = 0;
    endtask

    // Work out the result caused by one elevation sample
    task automatic predict_relief(input logic signed [23:0] smp);
        int unsigned w, h, r, x, y, slot;
        logic signed [25:0] d;
        logic [25:0] a, best;
        logic signed [23:0] ctr;
        t_relief e;
        bit last;
        w = cfg_w; h = cfg_h; r = cfg_r; x = col_cnt; y = row_cnt;
        if (w == 0) w = 1;
        if (w > lrwm_pkg::MAX_WIDTH) w = lrwm_pkg::MAX_WIDTH;
        if (h == 0) h = 1;
        if (r == 0 || r > lrwm_pkg::MAX_RADIUS) r = lrwm_pkg::MAX_RADIUS;
        if (x >= lrwm_pkg::MAX_WIDTH) x = 0;
        slot = y % lrwm_pkg::LINES;
        for (int dr = 0; dr < lrwm_pkg::SIDE; dr++)
            for (int dc = lrwm_pkg::SIDE - 1; dc > 0; dc--) win_q[dr][dc] = win_q[dr][dc-1];
        win_q[0][0] = smp;
        for (int dr = 1; dr < lrwm_pkg::SIDE; dr++)
            win_q[dr][0] = lines_q[(slot + lrwm_pkg::LINES - dr) % lrwm_pkg::LINES][x];
        lines_q[slot][x] = smp;
        last = (x + 1 >= w) && (y + 1 >= h);
        if (y >= 2 * r && x >= 2 * r) begin
            ctr = win_q[r][r];
            best = 0;
            for (int dr = 0; dr <= 2 * r; dr++)
                for (int dc = 0; dc <= 2 * r; dc++) begin
                    d = 26'(win_q[dr][dc]) - 26'(ctr);
                    a = d < 0 ? -d : d;
                    if (a > best) best = a;
                end
            e.rel = best > 26'hFFFFFF ? 24'hFFFFFF : best[23:0];
            if (!seen_valid) begin
                run_min = e.rel; run_max = e.rel; seen_valid = 1;
            end else begin
                if (e.rel < run_min) run_min = e.rel;
                if (e.rel > run_max) run_max = e.rel;
            end
            e.row = 16'(y - r); e.col = 10'(x - r);
            e.rmin = run_min; e.rmax = run_max; e.last = last;
            expected_q.push_back(e);
        end
        if (last) restart_frame();
        else if (x + 1 >= w) begin
            col_cnt = 0; row_cnt = y + 1;
        end else col_cnt = x + 1;
    endtask

    // Send one sample beat and predict it; valid stays up for a following beat
    task automatic send_sample(input logic [23:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_valid <= 1; s_data <= v;
        do @(posedge i_clk); while (!s_ready);
        predict_relief(v);
    endtask

    // Write one register through the APB port while the core is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        s_valid <= 0;
        wait (expected_q.size() == 0);
        repeat (30) @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            lrwm_pkg::CFG_WIDTH:  cfg_w = v[10:0];
            lrwm_pkg::CFG_HEIGHT: cfg_h = v[15:0];
            lrwm_pkg::CFG_RADIUS: cfg_r = v[2:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic set_grid(input int w, input int h, input int r);
        write_reg(lrwm_pkg::CFG_WIDTH, w);
        write_reg(lrwm_pkg::CFG_HEIGHT, h);
        write_reg(lrwm_pkg::CFG_RADIUS, r);
    endtask

    function automatic logic [23:0] rand_elev();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(0, 40));
            default: return 24'($urandom);
        endcase
    endfunction

    // Send whole frames of the current grid
    task automatic send_frames(input int n);
        int w, h;
        w = cfg_w == 0 ? 1 : (cfg_w > lrwm_pkg::MAX_WIDTH ? lrwm_pkg::MAX_WIDTH : cfg_w);
        h = cfg_h == 0 ? 1 : cfg_h;
        repeat (n * w * h) send_sample(rand_elev());
    endtask

    // Directed: extremes and special cases on small grids
    task automatic test_directed();
        set_grid(3, 3, 1);
        send_sample(24'h800000); send_sample(24'h7FFFFF); send_sample(24'h800000);
        send_sample(24'h7FFFFF); send_sample(24'h800000); send_sample(24'h7FFFFF);
        send_sample(24'h000000); send_sample(24'hFFFFFF); send_sample(24'h7FFFFF);
        set_grid(2, 2, 1);              // grid smaller than the window
        send_frames(1);
        set_grid(0, 0, 0);              // zero width, height, radius
        send_frames(1);
        set_grid(3, 4, 7);              // radius saturates
        send_frames(1);
    endtask

    // Random frames over several geometries
    task automatic test_random(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 4))
                0: set_grid($urandom_range(3, 12), $urandom_range(3, 8), 1);
                1: set_grid($urandom_range(5, 14), $urandom_range(5, 8), 2);
                2: set_grid(11, 11, 5);
                3: set_grid($urandom_range(1, 20), $urandom_range(1, 6), $urandom_range(0, 7));
                default: set_grid($urandom_range(7, 16), 7, 3);
            endcase
            send_frames(1);
            sent += (cfg_w == 0 ? 1 : cfg_w) * (cfg_h == 0 ? 1 : cfg_h);
        end
    endtask

    // Receiver back-pressure on a result-dense grid, then the largest width
    task automatic test_pressure();
        set_grid(4, 40, 1);
        hold_off = 400;
        send_frames(1);
        set_grid(2047, 1, 1);
        send_frames(1);
        set_grid(12, 1, 1);
        write_reg(lrwm_pkg::CFG_HEIGHT, 65535);  // then restart with a sane height
        set_grid(6, 6, 2);
        send_frames(1);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_ready <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                m_ready <= 0;
                hold_off--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                m_ready <= 1;
            end else m_ready <= 1;
        end
    end

    // Compare every result beat with the oldest expectation
    initial forever begin
        t_relief e, got;
        @(posedge i_clk);
        if (i_rst_n && m_valid && m_ready) begin
            got = {m_data[15:0], m_data[25:16], m_data[49:26], m_data[73:50],
                   m_data[97:74], m_last};
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, got);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (got !== e) begin
                    $display("%0t mismatch expected %h actual %h", $realtime, e, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("local_relief_window_max_core test failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        restart_frame();
        test_directed();
        test_pressure();
        test_random(200);
        idle_on = 0;
        test_random(100);
        s_valid <= 0;
        wait (expected_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("local_relief_window_max_core test passed");
        else
            $display("local_relief_window_max_core test failed");
        $finish;
    end
endmodule
